>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

>>> hdl/gdjs_pkg.sv
package gdjs_pkg;

  localparam int MAX_JOBS_DEF = 32;

  localparam int ID_W   = 8;
  localparam int DL_W   = 16;
  localparam int PR_W   = 16;
  localparam int SLOT_W = 6;
  localparam int TOT_W  = 22;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
    logic [PR_W-1:0] pr;
  } job_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SCAN,
    S_PLACE,
    S_EMIT,
    S_FETCH,
    S_TOTAL
  } state_e;

endpackage

>>> hdl/gdjs_ram.sv
module gdjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/greedy_deadline_job_sequencer.sv
// Greedy job sequencer with deadlines. Jobs are loaded one beat per cycle (up to
// MAX_JOBS; extra jobs are dropped and flag overflow); the beat with last_job set
// starts scheduling, and the input stalls until the run's results are out. Each of
// the n stored jobs costs one selection pass over the job memory (one read per
// cycle through the single read port) to find the highest remaining profit, then
// a backward slot search from min(deadline, n) down to the first free slot, if any.
// The slots are then walked in order, each occupied slot is emitted with its job
// id, and a total-profit result ends the run; any output stall holds the walk.
`include "assert_macros.svh"

module greedy_deadline_job_sequencer #(
  parameter int MAX_JOBS = gdjs_pkg::MAX_JOBS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [gdjs_pkg::ID_W-1:0]  job_id_i,
  input  logic [gdjs_pkg::DL_W-1:0]  deadline_i,
  input  logic [gdjs_pkg::PR_W-1:0]  profit_i,
  input  logic                       last_job_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [gdjs_pkg::SLOT_W-1:0] slot_index_o,
  output logic [gdjs_pkg::ID_W-1:0]  job_id_res_o,
  output logic                       is_total_o,
  output logic [gdjs_pkg::TOT_W-1:0] total_profit_o,
  output logic                       overflow_o,
  output logic                       last_o
);

  import gdjs_pkg::*;

  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);

  state_e state_q, state_d;

  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       scan_q, scan_d;
  logic [CW-1:0]       round_q, round_d;
  logic [CW-1:0]       emit_q, emit_d;
  logic [CW-1:0]       lim_q, lim_d;
  logic                dropped_q, dropped_d;
  logic [MAX_JOBS-1:0] taken_q, taken_d;
  logic [MAX_JOBS-1:0] done_q, done_d;
  logic [TOT_W-1:0]    sum_q, sum_d;
  logic                found_q, found_d;
  logic                pvalid_q, pvalid_d;
  logic [IW-1:0]       pidx_q, pidx_d;
  logic [IW-1:0]       best_idx_q, best_idx_d;
  job_t                best_q, best_d;

  logic                out_valid_q, out_valid_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [ID_W-1:0]     id_res_q, id_res_d;
  logic                is_total_q, is_total_d;
  logic [TOT_W-1:0]    total_q, total_d;
  logic                ovf_q, ovf_d;
  logic                last_q, last_d;

  logic                job_we;
  job_t                job_wdata;
  job_t                job_rdata;
  logic                slot_we;
  logic [IW-1:0]       slot_waddr;
  logic [ID_W-1:0]     slot_rdata;
  logic                out_free;
  logic                round_end;
  logic [IW-1:0]       lim_idx;

  assign job_wdata = '{id: job_id_i, dl: deadline_i, pr: profit_i};
  assign out_free  = !out_valid_q || !out_stall_i;
  assign lim_idx   = IW'(lim_q - 1'b1);
  assign slot_waddr = lim_idx;

  gdjs_ram #(
    .WIDTH($bits(job_t)),
    .DEPTH(MAX_JOBS)
  ) u_job_ram (
    .clk_i  (clk_i),
    .we_i   (job_we),
    .waddr_i(IW'(count_q)),
    .wdata_i(job_wdata),
    .raddr_i(IW'(scan_q)),
    .rdata_o(job_rdata)
  );

  gdjs_ram #(
    .WIDTH(ID_W),
    .DEPTH(MAX_JOBS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (slot_we),
    .waddr_i(slot_waddr),
    .wdata_i(best_q.id),
    .raddr_i(IW'(emit_q)),
    .rdata_o(slot_rdata)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    round_d     = round_q;
    emit_d      = emit_q;
    lim_d       = lim_q;
    dropped_d   = dropped_q;
    taken_d     = taken_q;
    done_d      = done_q;
    sum_d       = sum_q;
    found_d     = found_q;
    pvalid_d    = pvalid_q;
    pidx_d      = pidx_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    slot_d      = slot_q;
    id_res_d    = id_res_q;
    is_total_d  = is_total_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    job_we      = 1'b0;
    slot_we     = 1'b0;
    round_end   = 1'b0;

    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (count_q < CW'(MAX_JOBS)) begin
            job_we  = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (last_job_i) begin
            state_d  = S_SCAN;
            done_d   = '0;
            scan_d   = '0;
            round_d  = '0;
            pvalid_d = 1'b0;
            found_d  = 1'b0;
          end
        end
      end

      S_SCAN: begin
        // the compare sees the data for the address issued in the cycle before
        if (scan_q < count_q) begin
          pvalid_d = 1'b1;
          pidx_d   = IW'(scan_q);
          scan_d   = scan_q + 1'b1;
        end else begin
          pvalid_d = 1'b0;
        end
        // strict compare keeps the earliest job among equal profits
        if (pvalid_q && !done_q[pidx_q] && (!found_q || job_rdata.pr > best_q.pr)) begin
          found_d    = 1'b1;
          best_idx_d = pidx_q;
          best_d     = job_rdata;
        end
        if (scan_q == count_q && !pvalid_q) begin
          state_d            = S_PLACE;
          done_d[best_idx_q] = 1'b1;
          lim_d = (best_q.dl < DL_W'(count_q)) ? CW'(best_q.dl) : count_q;
        end
      end

      S_PLACE: begin
        if (lim_q == '0) begin
          round_end = 1'b1;
        end else if (!taken_q[lim_idx]) begin
          slot_we          = 1'b1;
          taken_d[lim_idx] = 1'b1;
          sum_d            = sum_q + TOT_W'(best_q.pr);
          round_end        = 1'b1;
        end else begin
          lim_d = lim_q - 1'b1;
        end
        if (round_end) begin
          round_d = round_q + 1'b1;
          if (CW'(round_q + 1'b1) == count_q) begin
            state_d = S_EMIT;
            emit_d  = '0;
          end else begin
            state_d  = S_SCAN;
            scan_d   = '0;
            pvalid_d = 1'b0;
            found_d  = 1'b0;
          end
        end
      end

      S_EMIT: begin
        if (emit_q == count_q) begin
          state_d = S_TOTAL;
        end else if (taken_q[IW'(emit_q)]) begin
          state_d = S_FETCH;
        end else begin
          emit_d = emit_q + 1'b1;
        end
      end

      S_FETCH: begin
        // read address is still emit_q, so slot_rdata holds
        if (out_free) begin
          out_valid_d = 1'b1;
          slot_d      = SLOT_W'(emit_q);
          id_res_d    = slot_rdata;
          is_total_d  = 1'b0;
          total_d     = '0;
          ovf_d       = dropped_q;
          last_d      = 1'b0;
          emit_d      = emit_q + 1'b1;
          state_d     = S_EMIT;
        end
      end

      S_TOTAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          slot_d      = '0;
          id_res_d    = '0;
          is_total_d  = 1'b1;
          total_d     = sum_q;
          ovf_d       = dropped_q;
          last_d      = 1'b1;
          count_d     = '0;
          taken_d     = '0;
          sum_d       = '0;
          dropped_d   = 1'b0;
          state_d     = S_LOAD;
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      count_q     <= '0;
      scan_q      <= '0;
      round_q     <= '0;
      emit_q      <= '0;
      dropped_q   <= 1'b0;
      taken_q     <= '0;
      done_q      <= '0;
      sum_q       <= '0;
      found_q     <= 1'b0;
      pvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      round_q     <= round_d;
      emit_q      <= emit_d;
      dropped_q   <= dropped_d;
      taken_q     <= taken_d;
      done_q      <= done_d;
      sum_q       <= sum_d;
      found_q     <= found_d;
      pvalid_q    <= pvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q      <= lim_d;
    pidx_q     <= pidx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    slot_q     <= slot_d;
    id_res_q   <= id_res_d;
    is_total_q <= is_total_d;
    total_q    <= total_d;
    ovf_q      <= ovf_d;
    last_q     <= last_d;
  end

  assign in_stall_o     = (state_q != S_LOAD);
  assign out_valid_o    = out_valid_q;
  assign slot_index_o   = slot_q;
  assign job_id_res_o   = id_res_q;
  assign is_total_o     = is_total_q;
  assign total_profit_o = total_q;
  assign overflow_o     = ovf_q;
  assign last_o         = last_q;

  `ASSERT_PROP(a_count_bound, clk_i, rst_ni, count_q <= CW'(MAX_JOBS))
  `ASSERT_PROP(a_taken_bound, clk_i, rst_ni, $countones(taken_q) <= int'(count_q))
  `ASSERT_IMPLIES(a_slot_fill, clk_i, rst_ni, slot_we,
    ##1 ($countones(taken_q) == $past($countones(taken_q)) + 1))
  `ASSERT_IMPLIES(a_sum_moves, clk_i, rst_ni, !$stable(sum_q),
    $past(slot_we) || ($past(state_q) == S_TOTAL))
  `ASSERT_IMPLIES(a_scan_idx, clk_i, rst_ni, (state_q == S_SCAN) && pvalid_q,
    CW'(pidx_q) < count_q)

endmodule
